FILE: src/utf8_text_normalizer_unit_assert.svh
// Assertion macros shared by the text normalizer modules.
`ifndef UTF8_TEXT_NORMALIZER_UNIT_ASSERT_SVH
`define UTF8_TEXT_NORMALIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define UTN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define UTN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/utn_pkg.sv
// Package with shared types, constants and helpers for the UTF-8 text normalizer.
package utn_pkg;

  // Default number of run entries between the classifier and the serializer.
  localparam int QueueDepth = 4;

  // Per-sequence status code carried on every output byte of a run.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_BAD_CONT  = 3'd3,
    ST_UNHANDLED = 3'd4
  } status_t;

  // One run: the output bytes caused by one input byte, first byte in slot 0.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_t         status;
    logic            text_end;
  } run_t;

  // Replacement characters.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // Printable ASCII bounds.
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Encoded sequences that are replaced.
  localparam logic [31:0] SEQ_HALF   = 32'h0000C2BD;
  localparam logic [31:0] SEQ_TIMES  = 32'h0000C397;
  localparam logic [31:0] SEQ_NDASH  = 32'h00E28093;
  localparam logic [31:0] SEQ_MDASH  = 32'h00E28094;
  localparam logic [31:0] SEQ_MINUS  = 32'h00E28892;

  // Encoded letters that pass through with an ok status.
  localparam logic [31:0] SEQ_A_UML  = 32'h0000C384;
  localparam logic [31:0] SEQ_O_UML  = 32'h0000C396;
  localparam logic [31:0] SEQ_U_UML  = 32'h0000C39C;
  localparam logic [31:0] SEQ_SZ     = 32'h0000C39F;
  localparam logic [31:0] SEQ_AL_UML = 32'h0000C3A4;
  localparam logic [31:0] SEQ_OL_UML = 32'h0000C3B6;
  localparam logic [31:0] SEQ_UL_UML = 32'h0000C3BC;
  localparam logic [31:0] SEQ_UL_CIR = 32'h0000C3BB;

  // True for the ASCII digits 0 through 9.
  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

FILE: src/utn_front.sv
// Front end: accepts text bytes, tracks open UTF-8 sequences and builds output runs.
`include "utf8_text_normalizer_unit_assert.svh"

module utn_front import utn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // string_end
  input  logic       q_full,
  output logic       q_push,
  output run_t       q_run
);

  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [2:0]  exp_r, exp_nxt;
  logic        digit_r, digit_nxt;

  logic            accept;
  logic            emit;
  logic [2:0]      seq_len;
  logic [2:0]      cnt_inc;
  logic [31:0]     seq_value;
  logic [3:0][7:0] raw_bytes;
  logic [1:0]      raw_last;
  logic [3:0][7:0] sub_bytes;
  logic [1:0]      sub_last;
  status_t         sub_status;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign seq_value = {pend_r, in_tdata};
  assign cnt_inc   = {1'b0, cnt_r} + 3'd1;

  // Sequence length from the lead byte; zero marks a bad lead.
  always_comb begin
    seq_len = 3'd0;
    if (!in_tdata[7]) begin
      seq_len = 3'd1;
    end else if (in_tdata[7:5] == 3'b110) begin
      seq_len = 3'd2;
    end else if (in_tdata[7:4] == 4'b1110) begin
      seq_len = 3'd3;
    end else if (in_tdata[7:3] == 5'b11110) begin
      seq_len = 3'd4;
    end
  end

  // Held bytes plus the current byte, in emission order.
  always_comb begin
    raw_bytes = '0;
    unique case (cnt_r)
      2'd1: begin
        raw_bytes[0] = pend_r[7:0];
        raw_bytes[1] = in_tdata;
        raw_last     = 2'd1;
      end
      2'd2: begin
        raw_bytes[0] = pend_r[15:8];
        raw_bytes[1] = pend_r[7:0];
        raw_bytes[2] = in_tdata;
        raw_last     = 2'd2;
      end
      2'd3: begin
        raw_bytes[0] = pend_r[23:16];
        raw_bytes[1] = pend_r[15:8];
        raw_bytes[2] = pend_r[7:0];
        raw_bytes[3] = in_tdata;
        raw_last     = 2'd3;
      end
      default: begin
        raw_bytes[0] = in_tdata;
        raw_last     = 2'd0;
      end
    endcase
  end

  // Substitution of a completed multi-byte sequence.
  always_comb begin
    sub_bytes  = raw_bytes;
    sub_last   = raw_last;
    sub_status = ST_OK;
    if (seq_value == SEQ_HALF) begin
      if (digit_r) begin
        sub_bytes = {CH_TWO, CH_SLASH, CH_ONE, CH_SPACE};
        sub_last  = 2'd3;
      end else begin
        sub_bytes = {8'h00, CH_TWO, CH_SLASH, CH_ONE};
        sub_last  = 2'd2;
      end
    end else if (seq_value == SEQ_TIMES) begin
      sub_bytes = {24'h000000, CH_X};
      sub_last  = 2'd0;
    end else if ((seq_value == SEQ_NDASH) || (seq_value == SEQ_MDASH) ||
                 (seq_value == SEQ_MINUS)) begin
      sub_bytes = {24'h000000, CH_DASH};
      sub_last  = 2'd0;
    end else if ((seq_value == SEQ_A_UML) || (seq_value == SEQ_O_UML) ||
                 (seq_value == SEQ_U_UML) || (seq_value == SEQ_SZ) ||
                 (seq_value == SEQ_AL_UML) || (seq_value == SEQ_OL_UML) ||
                 (seq_value == SEQ_UL_UML) || (seq_value == SEQ_UL_CIR)) begin
      sub_status = ST_OK;
    end else begin
      sub_status = ST_UNHANDLED;
    end
  end

  // Sequence tracking and run assembly for the byte on the input.
  always_comb begin
    emit           = 1'b0;
    q_run.bytes    = {24'h000000, in_tdata};
    q_run.last_idx = 2'd0;
    q_run.status   = ST_OK;
    q_run.text_end = in_tlast;
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    exp_nxt        = exp_r;
    digit_nxt      = digit_r;
    if (exp_r == 3'd0) begin
      if (seq_len == 3'd0) begin
        emit         = 1'b1;
        q_run.status = ST_BAD_LEAD;
        digit_nxt    = is_digit(in_tdata);
      end else if (seq_len == 3'd1) begin
        emit = 1'b1;
        if ((in_tdata < CH_PRINT_LO) || (in_tdata > CH_PRINT_HI)) begin
          q_run.status = ST_UNHANDLED;
        end
        digit_nxt = is_digit(in_tdata);
      end else if (in_tlast) begin
        emit         = 1'b1;
        q_run.status = ST_TRUNC;
      end else begin
        pend_nxt = {16'h0000, in_tdata};
        cnt_nxt  = 2'd1;
        exp_nxt  = seq_len;
      end
    end else begin
      if (in_tdata[7:6] != 2'b10) begin
        emit           = 1'b1;
        q_run.bytes    = raw_bytes;
        q_run.last_idx = raw_last;
        q_run.status   = ST_BAD_CONT;
        digit_nxt      = is_digit(in_tdata);
        pend_nxt       = '0;
        cnt_nxt        = 2'd0;
        exp_nxt        = 3'd0;
      end else if (cnt_inc >= exp_r) begin
        emit           = 1'b1;
        q_run.bytes    = sub_bytes;
        q_run.last_idx = sub_last;
        q_run.status   = sub_status;
        digit_nxt      = is_digit(in_tdata);
        pend_nxt       = '0;
        cnt_nxt        = 2'd0;
        exp_nxt        = 3'd0;
      end else if (in_tlast) begin
        emit           = 1'b1;
        q_run.bytes    = raw_bytes;
        q_run.last_idx = raw_last;
        q_run.status   = ST_TRUNC;
      end else begin
        pend_nxt = seq_value[23:0];
        cnt_nxt  = cnt_inc[1:0];
      end
    end
    // The end of the string returns all state to reset.
    if (in_tlast) begin
      pend_nxt  = '0;
      cnt_nxt   = 2'd0;
      exp_nxt   = 3'd0;
      digit_nxt = 1'b0;
    end
  end

  assign q_push = accept && emit;

  // State registers advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      cnt_r   <= 2'd0;
      exp_r   <= 3'd0;
      digit_r <= 1'b0;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      exp_r   <= exp_nxt;
      digit_r <= digit_nxt;
    end
  end

  `UTN_ASSERT_NOW(a_open_count, exp_r != 3'd0, (cnt_r != 2'd0) && ({1'b0, cnt_r} < exp_r), "held byte count does not fit the open sequence")
  `UTN_ASSERT_NEXT(a_end_clears, accept && in_tlast, (exp_r == 3'd0) && !digit_r, "state not cleared after end of string")
  `UTN_ASSERT_NOW(a_end_emits, accept && in_tlast, q_push, "end of string produced no run")

endmodule

FILE: src/utn_fifo.sv
// Run queue between the classifier front end and the byte serializer.
`include "utf8_text_normalizer_unit_assert.svh"

module utn_fifo import utn_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t wr_run,
  input  logic pop,
  output run_t head,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  run_t        mem_r [DEPTH];
  logic [AW:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW:0] rd_ptr_r, rd_ptr_nxt;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign head  = mem_r[rd_ptr_r[AW-1:0]];

  // Pointer advance.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + (AW+1)'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + (AW+1)'(1) : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= wr_run;
    end
  end

  `UTN_ASSERT_NOW(a_no_overflow, full, !push, "run pushed into a full queue")
  `UTN_ASSERT_NOW(a_no_underflow, empty, !pop, "run popped from an empty queue")
  `UTN_ASSERT_NOW(a_fill_bound, 1'b1, (AW+1)'(wr_ptr_r - rd_ptr_r) <= (AW+1)'(DEPTH), "queue fill exceeds its depth")

endmodule

FILE: src/utn_back.sv
// Back end: walks each queued run and drives its bytes through an output register.
module utn_back import utn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  run_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tlast,   // text_last
  output logic [3:0] out_tuser    // run_last, status[2:0]
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       run_last_r;
  logic       text_last_r;
  status_t    status_r;
  logic       load;
  logic       at_last;

  assign load    = !q_empty && (!valid_r || out_tready);
  assign at_last = (idx_r == head.last_idx);
  assign q_pop   = load && at_last;

  // Byte index within the head run and output valid.
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = at_last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r      <= head.bytes[idx_r];
      run_last_r  <= at_last;
      text_last_r <= at_last && head.text_end;
      status_r    <= head.status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = text_last_r;
  assign out_tuser  = {status_r, run_last_r};

endmodule

FILE: src/utf8_text_normalizer_unit.sv
// Top level of the UTF-8 text normalizer: front end, run queue and byte serializer.
//
// Takes one text byte per request and one output byte per cycle while out_tready is high.
// A byte is accepted in every cycle while the run queue has a free entry; bytes that leave
// a sequence open produce nothing, every other byte produces a run of one to four output
// bytes, and the serializer sends one byte of that run per cycle while out_tready is high,
// so the queue (QUEUE_DEPTH runs) absorbs those bursts. A run is written into the queue
// when its input byte is accepted; its bytes then pass through the output register. Each
// run carries run_last on its final byte, text_last on the final byte of a string, and one
// status code: 0 ok, 1 bad lead, 2 truncated, 3 bad continuation, 4 unhandled code.
module utf8_text_normalizer_unit import utn_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // in_byte
  input  logic       in_tlast,    // string_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tlast,   // text_last
  output logic [3:0] out_tuser    // run_last, status[2:0]
);

  run_t q_wr_run;
  run_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  utn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_run     (q_wr_run)
  );

  utn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_run (q_wr_run),
    .pop    (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  utn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: sim/utf8_text_normalizer_unit_tb.sv
// Testbench for the UTF-8 text normalizer: directed and random text streams checked byte by byte.
`timescale 1ns / 1ps

module utf8_text_normalizer_unit_tb;
  import utn_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 350;
  localparam int SETTLE_CYCLES = 16;

  // Characters written by the substitutions and the ranges the filter tests.
  localparam logic [7:0] SPACE    = 8'h20;
  localparam logic [7:0] ONE      = 8'h31;
  localparam logic [7:0] SLASH    = 8'h2F;
  localparam logic [7:0] TWO      = 8'h32;
  localparam logic [7:0] LOWER_X  = 8'h78;
  localparam logic [7:0] DASH     = 8'h2D;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;
  localparam logic [7:0] DIGIT_0  = 8'h30;
  localparam logic [7:0] DIGIT_9  = 8'h39;
  localparam logic [7:0] DEL      = 8'h7F;

  // Encoded sequences that are replaced.
  localparam logic [31:0] HALF_SEQ  = 32'h0000C2BD;
  localparam logic [31:0] TIMES_SEQ = 32'h0000C397;
  localparam logic [31:0] NDASH_SEQ = 32'h00E28093;
  localparam logic [31:0] MDASH_SEQ = 32'h00E28094;
  localparam logic [31:0] MINUS_SEQ = 32'h00E28892;

  // Two-byte letters that pass through with an ok status.
  localparam logic [15:0] LETTERS [8] = '{16'hC384, 16'hC396, 16'hC39C, 16'hC39F,
                                          16'hC3A4, 16'hC3B6, 16'hC3BC, 16'hC3BB};

  // One output byte as the receiver should see it.
  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;
    status_t    status;
  } text_out_t;

  // Tracks the filter state and the output bytes still owed by the block.
  class text_scoreboard;
    logic [23:0] held;
    logic [1:0]  held_count;
    logic [2:0]  open_len;
    bit          prev_digit;
    logic [7:0]  run[$];
    status_t     run_status;
    text_out_t   due[$];
    int          mismatches;

    function new();
      clear_state();
      prev_digit = 0;
      mismatches = 0;
    endfunction

    function void clear_state();
      held = '0;
      held_count = '0;
      open_len = '0;
    endfunction

    function bit is_dec(logic [7:0] c);
      return (c >= DIGIT_0) && (c <= DIGIT_9);
    endfunction

    // Append one byte to the run being built.
    function void add_byte(logic [7:0] b);
      run.insert(run.size(), b);
    endfunction

    // Append one expected output byte to the owed list.
    function void add_due(text_out_t e);
      due.insert(due.size(), e);
    endfunction

    // Emit n bytes of seq unchanged, first byte highest.
    function void put_raw(logic [31:0] seq, int n);
      for (int i = n - 1; i >= 0; i--) add_byte(seq[8*i +: 8]);
    endfunction

    // A complete sequence: substitute, pass through, or flag as unhandled.
    function void emit_sequence(logic [31:0] seq, int n);
      bit letter;
      letter = 0;
      foreach (LETTERS[i]) if (seq == {16'h0, LETTERS[i]}) letter = 1;
      run_status = ST_OK;
      if (n == 1) begin
        add_byte(seq[7:0]);
        if (seq[7:0] < PRINT_LO || seq[7:0] > PRINT_HI) run_status = ST_UNHANDLED;
      end else if (seq == HALF_SEQ) begin
        if (prev_digit) add_byte(SPACE);
        add_byte(ONE);
        add_byte(SLASH);
        add_byte(TWO);
      end else if (seq == TIMES_SEQ) begin
        add_byte(LOWER_X);
      end else if (seq == NDASH_SEQ || seq == MDASH_SEQ || seq == MINUS_SEQ) begin
        add_byte(DASH);
      end else begin
        put_raw(seq, n);
        if (!letter) run_status = ST_UNHANDLED;
      end
      prev_digit = is_dec(seq[7:0]);
    endfunction

    // An accepted input byte: advance the state and queue the bytes it causes.
    function void note_input(logic [7:0] b, logic fin);
      logic [31:0] seq;
      int n, lead_len;
      run.delete();
      run_status = ST_OK;
      if (open_len == 0) begin
        if (!b[7]) lead_len = 1;
        else if (b[7:5] == 3'b110) lead_len = 2;
        else if (b[7:4] == 4'b1110) lead_len = 3;
        else if (b[7:3] == 5'b11110) lead_len = 4;
        else lead_len = 0;
        if (lead_len == 0) begin
          add_byte(b);
          run_status = ST_BAD_LEAD;
          prev_digit = is_dec(b);
        end else if (lead_len == 1) begin
          emit_sequence({24'h0, b}, 1);
        end else if (fin) begin
          add_byte(b);
          run_status = ST_TRUNC;
        end else begin
          held = {16'h0, b};
          held_count = 2'd1;
          open_len = 3'(lead_len);
        end
      end else begin
        n = int'(held_count) + 1;
        seq = {held, b};
        if (b[7:6] != 2'b10) begin
          // The offending byte ends the sequence and is not reused as a lead.
          put_raw(seq, n);
          run_status = ST_BAD_CONT;
          prev_digit = is_dec(b);
          clear_state();
        end else if (n >= int'(open_len)) begin
          emit_sequence(seq, n);
          clear_state();
        end else if (fin) begin
          put_raw(seq, n);
          run_status = ST_TRUNC;
        end else begin
          held = seq[23:0];
          held_count = 2'(n);
        end
      end
      if (fin) begin
        clear_state();
        prev_digit = 0;
      end
      for (int k = 0; k < run.size(); k++)
        add_due('{out_byte: run[k], run_last: (k == run.size() - 1),
                  text_last: (k == run.size() - 1) && fin, status: run_status});
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 60) $display("%0t mismatch: %s", $time, msg);
    endtask

    // An accepted output byte against the oldest expectation.
    task check_result(logic [7:0] b, logic run_last, logic text_last, logic [2:0] status);
      text_out_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("byte %02h arrived with nothing expected", b));
        return;
      end
      want = due.pop_front();
      if (b !== want.out_byte)
        report_mismatch($sformatf("byte %02h, expected %02h", b, want.out_byte));
      if (run_last !== want.run_last)
        report_mismatch($sformatf("run_last %b on byte %02h, expected %b",
                                  run_last, b, want.run_last));
      if (text_last !== want.text_last)
        report_mismatch($sformatf("text_last %b on byte %02h, expected %b",
                                  text_last, b, want.text_last));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d on byte %02h, expected %s",
                                  status, b, want.status.name()));
    endtask

    function int outstanding();
      return due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [3:0] out_tuser;

  text_scoreboard sb = new();
  bit         tx_idle = 0;
  bit         rx_idle = 0;
  int         rx_hold_cycles = 0;
  int         items_sent = 0;
  logic [7:0] text_buf[$];

  // Directed requests: bit 8 marks the end of a string.
  localparam logic [8:0] DIRECTED [27] = '{
    9'h037, 9'h0C2, 9'h0BD,          // half after a digit
    9'h0C3, 9'h097,                  // times sign
    9'h0E2, 9'h080, 9'h093,          // en dash
    9'h0E2, 9'h088, 9'h092,          // minus sign
    9'h0C2, 9'h0BD,                  // half after a non-digit
    9'h0C3, 9'h084,                  // accepted letter
    9'h000, 9'h0FF,                  // control byte, bad lead
    9'h0E2, 9'h041,                  // bad continuation
    9'h0F0, 9'h09F, 9'h098, 9'h080,  // valid four-byte, unhandled
    9'h0F0, 9'h09F, 9'h198,          // truncated at end of string
    9'h1C2                           // lone lead at end of string
  };

  utf8_text_normalizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser[0], out_tlast, out_tuser[3:1]);
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
    end
  end

  // Receiver: a random stall before each byte, plus any long hold requested.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = (rx_idle ? $urandom_range(0, 14) : 0) + rx_hold_cycles;
      rx_hold_cycles = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait for every owed output byte.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Append one byte to the string being built.
  function automatic void buf_byte(logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  function automatic void add_seq(logic [23:0] v, int n);
    for (int i = n - 1; i >= 0; i--) buf_byte(v[8*i +: 8]);
  endfunction

  function automatic logic [7:0] lead_byte(int len);
    case (len)
      2: return {3'b110, 5'($urandom)};
      3: return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // One string of mostly well-formed characters with some damage mixed in.
  task automatic send_text(input int n_chars);
    int kind, len, cut_at;
    logic [1:0] top;
    bit cut;
    text_buf.delete();
    cut = 0;
    for (int c = 0; c < n_chars && !cut; c++) begin
      kind = $urandom_range(0, 19);
      case (kind)
        0, 1, 2, 3, 4, 5: buf_byte(8'($urandom_range(PRINT_LO, PRINT_HI)));
        6, 7: buf_byte(8'($urandom_range(DIGIT_0, DIGIT_9)));
        8: buf_byte($urandom_range(0, 1) ? DEL : 8'($urandom_range(0, 31)));
        9: add_seq(HALF_SEQ[23:0], 2);
        10: add_seq(TIMES_SEQ[23:0], 2);
        11: begin
          case ($urandom_range(0, 2))
            0: add_seq(NDASH_SEQ[23:0], 3);
            1: add_seq(MDASH_SEQ[23:0], 3);
            default: add_seq(MINUS_SEQ[23:0], 3);
          endcase
        end
        12: add_seq({8'h0, LETTERS[$urandom_range(0, 7)]}, 2);
        13, 14: begin
          len = $urandom_range(2, 4);
          buf_byte(lead_byte(len));
          repeat (len - 1) buf_byte(cont_byte());
        end
        15: buf_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                          : 8'($urandom_range(8'hF8, 8'hFF)));
        16: begin
          // A broken continuation somewhere inside the sequence.
          len = $urandom_range(2, 4);
          cut_at = $urandom_range(1, len - 1);
          buf_byte(lead_byte(len));
          repeat (cut_at - 1) buf_byte(cont_byte());
          top = 2'($urandom_range(0, 2));
          if (top == 2'b10) top = 2'b11;
          buf_byte({top, 6'($urandom)});
        end
        17: begin
          // The string ends before the sequence is complete.
          len = $urandom_range(2, 4);
          buf_byte(lead_byte(len));
          repeat ($urandom_range(0, len - 2)) buf_byte(cont_byte());
          cut = 1;
        end
        18: buf_byte(8'($urandom));
        default: begin
          buf_byte(8'($urandom_range(DIGIT_0, DIGIT_9)));
          add_seq(HALF_SEQ[23:0], 2);
        end
      endcase
    end
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_texts_until(input int target);
    while (items_sent < target) send_text($urandom_range(1, 12));
  endtask

  initial begin : stimulus
    int pressure_end;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings back to back with no idling.
    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    // Random strings with idling on both sides.
    tx_idle = 1;
    rx_idle = 1;
    send_texts_until(150);

    // Receiver holds off while the sender keeps offering, then the sender waits.
    tx_idle = 0;
    rx_hold_cycles = 150;
    pressure_end = items_sent + 40;
    send_texts_until(pressure_end);
    wait_drained();

    // Full speed, then idling on one side at a time.
    rx_idle = 0;
    send_texts_until(250);
    tx_idle = 1;
    send_texts_until(300);
    tx_idle = 0;
    rx_idle = 1;
    send_texts_until(ITEM_TARGET);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
